/* hdl/hbkt_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the usage-to-ascii table for the typematic decoder
// no dependencies
package hbkt_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int SLOT_W    = $clog2(KEY_SLOTS);
  localparam int CODE_W    = 8;
  localparam int CHAR_W    = 7;
  localparam int CNT_W     = 16;
  localparam int BIT_W     = $clog2(CNT_W);
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_REPEAT_DELAY     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_PERIOD    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEYBOARD_ENABLED = 2'd2;

  localparam logic [CNT_W-1:0] DELAY_RESET  = 16'd600;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd40;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic                        tick;
    code_t [KEY_SLOTS-1:0]       keys;
    logic  [KEY_SLOTS-1:0]       fresh;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    code_t             usage_code;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] repeat_delay;
    logic [CNT_W-1:0] rpt_interval;
    logic             keyboard_enabled;
  } cfg_t;

  function automatic logic [CHAR_W-1:0] usage_to_ascii(input code_t code);
    logic [7:0] ch;
    ch = 8'h00;
    if (code >= 8'h04 && code <= 8'h1d) begin
      ch = 8'h61 + (code - 8'h04);
    end else if (code >= 8'h1e && code <= 8'h26) begin
      ch = 8'h31 + (code - 8'h1e);
    end else begin
      case (code)
        8'h27: ch = 8'h30;
        8'h28: ch = 8'h0a;
        8'h29: ch = 8'h1b;
        8'h2a: ch = 8'h08;
        8'h2b: ch = 8'h09;
        8'h2c: ch = 8'h20;
        8'h2d: ch = 8'h2d;
        8'h2e: ch = 8'h3d;
        8'h2f: ch = 8'h5b;
        8'h30: ch = 8'h5d;
        8'h31: ch = 8'h5c;
        8'h33: ch = 8'h3b;
        8'h34: ch = 8'h27;
        8'h35: ch = 8'h60;
        8'h36: ch = 8'h2c;
        8'h37: ch = 8'h2e;
        8'h38: ch = 8'h2f;
        default: ch = 8'h00;
      endcase
    end
    return ch[CHAR_W-1:0];
  endfunction

endpackage

/* hdl/hbkt_front.sv */
`timescale 1ns / 1ps
// input side: accepts reports and ticks, keeps the held report, marks new presses
// depends on hbkt_pkg
module hbkt_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  hbkt_pkg::code_t [hbkt_pkg::KEY_SLOTS-1:0] keys,
  input  logic                                 enabled,
  input  logic                                 q_full,
  output logic                                 q_push,
  output hbkt_pkg::item_t                      q_data
);

  hbkt_pkg::code_t [hbkt_pkg::KEY_SLOTS-1:0] held;
  logic [hbkt_pkg::KEY_SLOTS-1:0]            fresh;
  logic                                      accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (!kind || enabled);

  always_comb begin
    logic hit;
    for (int i = 0; i < hbkt_pkg::KEY_SLOTS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < hbkt_pkg::KEY_SLOTS; j++) begin
        if (held[j] == keys[i]) hit = 1'b1;
      end
      fresh[i] = (keys[i] != '0) && !hit;
    end
  end

  assign q_data.tick  = kind;
  assign q_data.keys  = kind ? held : keys;
  assign q_data.fresh = kind ? '0 : fresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept && !kind) begin
      held <= keys;
    end
  end

endmodule

/* hdl/hbkt_queue.sv */
`timescale 1ns / 1ps
// two-entry queue between front and back
// depends on hbkt_pkg
module hbkt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hbkt_pkg::item_t push_data,
  input  logic            pop,
  output hbkt_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  hbkt_pkg::item_t entries [2];
  logic            wp;
  logic            rp;
  logic [1:0]      count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/hbkt_back.sv */
`timescale 1ns / 1ps
// execution side: press walk, tick walk over held codes, repeat counters, output stage
// depends on hbkt_pkg
module hbkt_back (
  input  logic              clk,
  input  logic              rst,
  input  hbkt_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  hbkt_pkg::item_t   q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output hbkt_pkg::result_t out_result
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REPORT = 3'd1;
  localparam logic [2:0] S_TSEL   = 3'd2;
  localparam logic [2:0] S_TREAD  = 3'd3;
  localparam logic [2:0] S_TDIV   = 3'd4;
  localparam logic [2:0] S_TEMIT  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]                     state;
  hbkt_pkg::item_t                item;
  logic [hbkt_pkg::SLOT_W-1:0]    slot;
  hbkt_pkg::code_t                last_code;
  hbkt_pkg::code_t                cur_code;
  logic [hbkt_pkg::CNT_W-1:0]     div_sh;
  logic [hbkt_pkg::CNT_W-1:0]     rem;
  logic [hbkt_pkg::BIT_W-1:0]     bitn;

  logic [hbkt_pkg::CNT_W-1:0]     counts [256];
  logic [hbkt_pkg::CNT_W-1:0]     rd_data;

  logic                           pend_v;
  hbkt_pkg::result_t              pend;
  logic                           out_v;
  hbkt_pkg::result_t              out_r;

  logic                           out_free;
  logic                           can_push;
  logic                           produce;
  logic                           finish;
  logic                           pend_move;
  logic                           hold;
  hbkt_pkg::result_t              res;
  logic                           mem_we;
  hbkt_pkg::code_t                mem_wa;
  logic [hbkt_pkg::CNT_W-1:0]     mem_wd;
  hbkt_pkg::code_t                slot_code;
  logic [hbkt_pkg::CHAR_W-1:0]    slot_char;
  logic [hbkt_pkg::CHAR_W-1:0]    cur_char;
  hbkt_pkg::code_t                next_code;
  logic                           found;
  logic [hbkt_pkg::CNT_W-1:0]     cnt_inc;
  logic [hbkt_pkg::CNT_W-1:0]     diff_inc;
  logic [hbkt_pkg::CNT_W:0]       trial;
  logic [hbkt_pkg::CNT_W:0]       trial_sub;
  logic [hbkt_pkg::CNT_W-1:0]     rem_next;

  // smallest held code above the last one handled
  always_comb begin
    found     = 1'b0;
    next_code = '1;
    for (int i = 0; i < hbkt_pkg::KEY_SLOTS; i++) begin
      if (item.keys[i] > last_code && (!found || item.keys[i] < next_code)) begin
        found     = 1'b1;
        next_code = item.keys[i];
      end
    end
  end

  assign cnt_inc   = rd_data + 1'b1;
  assign diff_inc  = cnt_inc - cfg.repeat_delay;
  assign trial     = {rem, div_sh[hbkt_pkg::CNT_W-1]};
  assign trial_sub = trial - {1'b0, cfg.rpt_interval};
  assign rem_next  = (trial >= {1'b0, cfg.rpt_interval}) ? trial_sub[hbkt_pkg::CNT_W-1:0]
                                                          : trial[hbkt_pkg::CNT_W-1:0];

  assign slot_code = item.keys[slot];
  assign slot_char = hbkt_pkg::usage_to_ascii(slot_code);
  assign cur_char  = hbkt_pkg::usage_to_ascii(cur_code);

  assign out_free  = !out_v || !out_stall;
  assign can_push  = !pend_v || out_free;
  assign pend_move = pend_v && out_free && (pend.last_of_run || produce);

  always_comb begin
    q_pop   = 1'b0;
    produce = 1'b0;
    finish  = 1'b0;
    hold    = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = cur_code;
    mem_wd  = cnt_inc;
    res.ascii_char  = cur_char;
    res.usage_code  = cur_code;
    res.last_of_run = 1'b0;
    case (state)
      S_IDLE: begin
        q_pop = !q_empty;
      end
      S_REPORT: begin
        res.ascii_char = slot_char;
        res.usage_code = slot_code;
        if (item.fresh[slot]) begin
          if (slot_char != '0 && !can_push) begin
            hold = 1'b1;
          end else begin
            mem_we  = 1'b1;
            mem_wa  = slot_code;
            mem_wd  = {{(hbkt_pkg::CNT_W-1){1'b0}}, 1'b1};
            produce = (slot_char != '0);
          end
        end
      end
      S_TREAD: begin
        mem_we = 1'b1;
      end
      S_TEMIT: begin
        if (cur_char != '0) begin
          hold    = !can_push;
          produce = can_push;
        end
      end
      S_FINISH: begin
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) counts[mem_wa] <= mem_wd;
    rd_data <= counts[next_code];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            item      <= q_head;
            slot      <= '0;
            last_code <= '0;
            state     <= q_head.tick ? S_TSEL : S_REPORT;
          end
        end
        S_REPORT: begin
          if (!hold) begin
            if (slot == hbkt_pkg::SLOT_W'(hbkt_pkg::KEY_SLOTS - 1)) begin
              state <= S_FINISH;
            end else begin
              slot <= slot + 1'b1;
            end
          end
        end
        S_TSEL: begin
          if (found) begin
            cur_code  <= next_code;
            last_code <= next_code;
            state     <= S_TREAD;
          end else begin
            state <= S_FINISH;
          end
        end
        S_TREAD: begin
          if (cnt_inc < cfg.repeat_delay) begin
            state <= S_TSEL;
          end else if (cfg.rpt_interval == '0) begin
            state <= (diff_inc == '0) ? S_TEMIT : S_TSEL;
          end else begin
            rem    <= '0;
            div_sh <= diff_inc;
            bitn   <= '0;
            state  <= S_TDIV;
          end
        end
        S_TDIV: begin
          rem    <= rem_next;
          div_sh <= {div_sh[hbkt_pkg::CNT_W-2:0], 1'b0};
          bitn   <= bitn + 1'b1;
          if (bitn == hbkt_pkg::BIT_W'(hbkt_pkg::CNT_W - 1)) begin
            state <= (rem_next == '0) ? S_TEMIT : S_TSEL;
          end
        end
        S_TEMIT: begin
          if (!hold) state <= S_TSEL;
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // one result held back so the final one of a run can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (produce) begin
        pend_v <= 1'b1;
        pend   <= res;
      end else if (pend_move) begin
        pend_v <= 1'b0;
      end else if (finish && pend_v) begin
        pend.last_of_run <= 1'b1;
      end
      if (pend_move) begin
        out_v <= 1'b1;
        out_r <= pend;
      end else if (out_v && !out_stall) begin
        out_v <= 1'b0;
      end
    end
  end

  assign out_valid  = out_v;
  assign out_result = out_r;

endmodule

/* hdl/hid_boot_keyboard_typematic_top.sv */
`timescale 1ns / 1ps
// Boot-keyboard report decoder with autorepeat. In the back end a report passes through
// dequeue, one step per key slot, and close. A tick passes through dequeue, the search that
// finds no further held code, and close, plus, for each distinct held code, a select and a
// counter read, a bit-serial remainder division over the counter bits when its count has
// reached the delay and the period is nonzero, and an emit step when a repeat falls due.
// Ticks while the keyboard is disabled are dropped at the input. A two-entry queue lets the
// input side take new transactions while the back end works; output stalls hold the back end
// and, once the queue is full, the input.
// depends on hbkt_pkg, hbkt_front, hbkt_queue, hbkt_back
module hid_boot_keyboard_typematic_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hbkt_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [hbkt_pkg::CNT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [7:0]                        key_0,
  input  logic [7:0]                        key_1,
  input  logic [7:0]                        key_2,
  input  logic [7:0]                        key_3,
  input  logic [7:0]                        key_4,
  input  logic [7:0]                        key_5,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hbkt_pkg::CHAR_W-1:0]       ascii_char,
  output logic [7:0]                        usage_code,
  output logic                              last_of_run
);

  hbkt_pkg::cfg_t                            cfg;
  hbkt_pkg::code_t [hbkt_pkg::KEY_SLOTS-1:0] keys;
  logic                                      q_push;
  logic                                      q_pop;
  logic                                      q_full;
  logic                                      q_empty;
  hbkt_pkg::item_t                           q_data;
  hbkt_pkg::item_t                           q_head;
  hbkt_pkg::result_t                         result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_delay     <= hbkt_pkg::DELAY_RESET;
      cfg.rpt_interval     <= hbkt_pkg::PERIOD_RESET;
      cfg.keyboard_enabled <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        hbkt_pkg::REG_REPEAT_DELAY:     cfg.repeat_delay     <= cfg_data;
        hbkt_pkg::REG_REPEAT_PERIOD:    cfg.rpt_interval     <= cfg_data;
        hbkt_pkg::REG_KEYBOARD_ENABLED: cfg.keyboard_enabled <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    keys = '0;
    keys[0] = key_0;
    keys[1] = key_1;
    keys[2] = key_2;
    keys[3] = key_3;
    keys[4] = key_4;
    keys[5] = key_5;
  end

  hbkt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .keys     (keys),
    .enabled  (cfg.keyboard_enabled),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  hbkt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  hbkt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (result)
  );

  assign ascii_char  = result.ascii_char;
  assign usage_code  = result.usage_code;
  assign last_of_run = result.last_of_run;

endmodule

/* verif/hid_boot_keyboard_typematic_top_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for hid_boot_keyboard_typematic_top: directed reports and ticks,
// then randomized typing sessions under several repeat settings, checked against a predictor
// depends on hbkt_pkg and the typematic decoder rtl
module hid_boot_keyboard_typematic_top_test;
  import hbkt_pkg::*;

  localparam logic KIND_REPORT     = 1'b0;
  localparam logic KIND_TICK       = 1'b1;
  localparam int   SETTLE_CYCLES   = 400;
  localparam int   CYCLE_LIMIT     = 400000;
  localparam int   ITEMS_PER_PHASE = 80;

  typedef code_t [KEY_SLOTS-1:0] report_t;

  class typematic_checker;
    logic [CNT_W-1:0] delay;
    logic [CNT_W-1:0] period;
    logic             enabled;
    report_t          held;
    logic [CNT_W-1:0] counts [256];
    result_t          burst [$];
    result_t          pending_chars [$];
    int               mismatches;

    function new();
      delay      = DELAY_RESET;
      period     = PERIOD_RESET;
      enabled    = 1'b0;
      held       = '0;
      mismatches = 0;
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
      case (idx)
        REG_REPEAT_DELAY:     delay = value;
        REG_REPEAT_PERIOD:    period = value;
        REG_KEYBOARD_ENABLED: enabled = value[0];
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] char_of(code_t code);
      logic [CHAR_W-1:0] ch;
      ch = '0;
      if (code >= 8'h04 && code <= 8'h1d) begin
        ch = 7'h61 + 7'(code - 8'h04);
      end else if (code == 8'h27) begin
        ch = 7'h30;
      end else if (code >= 8'h1e && code <= 8'h26) begin
        ch = 7'h31 + 7'(code - 8'h1e);
      end else begin
        case (code)
          8'h28: ch = 7'h0a;
          8'h29: ch = 7'h1b;
          8'h2a: ch = 7'h08;
          8'h2b: ch = 7'h09;
          8'h2c: ch = 7'h20;
          8'h2d: ch = 7'h2d;
          8'h2e: ch = 7'h3d;
          8'h2f: ch = 7'h5b;
          8'h30: ch = 7'h5d;
          8'h31: ch = 7'h5c;
          8'h33: ch = 7'h3b;
          8'h34: ch = 7'h27;
          8'h35: ch = 7'h60;
          8'h36: ch = 7'h2c;
          8'h37: ch = 7'h2e;
          8'h38: ch = 7'h2f;
          default: ch = '0;
        endcase
      end
      return ch;
    endfunction

    function bit listed(report_t list, code_t code);
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (list[i] == code) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void add_char(code_t code);
      result_t r;
      r.ascii_char  = char_of(code);
      r.usage_code  = code;
      r.last_of_run = 1'b0;
      if (r.ascii_char != 0 && burst.size() < KEY_SLOTS) burst.push_back(r);
    endfunction

    // expected characters for one accepted transaction
    function void predict_chars(logic item_kind, report_t keys);
      logic [CNT_W-1:0] cnt;
      logic [CNT_W-1:0] since;
      logic             fire;
      burst.delete();
      if (item_kind == KIND_REPORT) begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (keys[i] != 0 && !listed(held, keys[i])) begin
            counts[keys[i]] = 1;
            add_char(keys[i]);
          end
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (held[i] != 0 && !listed(keys, held[i])) counts[held[i]] = 0;
        end
        held = keys;
      end else if (enabled) begin
        for (int c = 1; c < 256; c++) begin
          if (listed(held, code_t'(c))) begin
            cnt       = counts[c] + 1'b1;
            counts[c] = cnt;
            since     = cnt - delay;
            if (cnt < delay) fire = 1'b0;
            else if (period == 0) fire = (cnt == delay);
            else fire = (since % period) == 0;
            if (fire) add_char(code_t'(c));
          end
        end
      end
      if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
      foreach (burst[i]) pending_chars.push_back(burst[i]);
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, code_t code, logic last);
      result_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character %0h from usage code %0h", ch, code);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (want.ascii_char !== ch) begin
        $error("ascii_char: expected %0h, actual %0h", want.ascii_char, ch);
        mismatches++;
      end
      if (want.usage_code !== code) begin
        $error("usage_code: expected %0h, actual %0h", want.usage_code, code);
        mismatches++;
      end
      if (want.last_of_run !== last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last_of_run, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = 1'b0;
  code_t                key_0 = '0;
  code_t                key_1 = '0;
  code_t                key_2 = '0;
  code_t                key_3 = '0;
  code_t                key_4 = '0;
  code_t                key_5 = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    ascii_char;
  code_t                usage_code;
  logic                 last_of_run;

  logic                 quiet = 1'b0;
  int                   cycles = 0;
  report_t              typed_keys = '0;
  typematic_checker     ledger = new();

  hid_boot_keyboard_typematic_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .key_0       (key_0),
    .key_1       (key_1),
    .key_2       (key_2),
    .key_3       (key_3),
    .key_4       (key_4),
    .key_5       (key_5),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ascii_char  (ascii_char),
    .usage_code  (usage_code),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) ledger.check_char(ascii_char, usage_code, last_of_run);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic report_t keys_of(code_t k0, code_t k1, code_t k2,
                                      code_t k3, code_t k4, code_t k5);
    return {k5, k4, k3, k2, k1, k0};
  endfunction

  function automatic report_t noise_keys();
    report_t keys;
    for (int i = 0; i < KEY_SLOTS; i++) keys[i] = code_t'($urandom_range(255));
    return keys;
  endfunction

  // next report of a typing session: mostly held keys, some presses and releases
  function automatic report_t next_report();
    report_t keys;
    int      r;
    int      src;
    int      dst;
    keys = typed_keys;
    if ($urandom_range(99) < 4) begin
      keys = noise_keys();
    end else begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        r = $urandom_range(99);
        if (r >= 55 && r < 70) keys[i] = '0;
        else if (r >= 70 && r < 92) keys[i] = code_t'($urandom_range(8'h38, 8'h04));
        else if (r >= 92) keys[i] = code_t'($urandom_range(255));
      end
      if ($urandom_range(99) < 6) begin
        src       = $urandom_range(KEY_SLOTS - 1);
        dst       = $urandom_range(KEY_SLOTS - 1);
        keys[dst] = keys[src];
      end
    end
    typed_keys = keys;
    return keys;
  endfunction

  task automatic send_item(input logic item_kind, input report_t keys);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= item_kind;
    key_0    <= keys[0];
    key_1    <= keys[1];
    key_2    <= keys[2];
    key_3    <= keys[3];
    key_4    <= keys[4];
    key_5    <= keys[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.predict_chars(item_kind, keys);
  endtask

  task automatic send_report(input report_t keys);
    send_item(KIND_REPORT, keys);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, noise_keys());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    ledger.set_reg(idx, value);
  endtask

  task automatic set_config(input logic [CNT_W-1:0] delay, input logic [CNT_W-1:0] period,
                            input logic enable);
    drain();
    write_reg(REG_REPEAT_DELAY, delay);
    write_reg(REG_REPEAT_PERIOD, period);
    write_reg(REG_KEYBOARD_ENABLED, CNT_W'(enable));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic typing_session(input int count, input int tick_pct);
    repeat (count) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      else send_report(next_report());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: ticks dropped, reports still decoded
    send_tick();
    send_report(keys_of(8'h04, 8'h1d, 8'h1e, 8'h27, 8'h28, 8'h38));
    send_report(keys_of(8'h04, 8'h1d, 8'h1e, 8'h27, 8'h28, 8'h38));
    send_report(keys_of(8'h00, 8'h1d, 8'h00, 8'h27, 8'h00, 8'h38));
    send_report(keys_of(8'h32, 8'h39, 8'hff, 8'h01, 8'h03, 8'h00));
    send_report(keys_of(8'h05, 8'h05, 8'h2c, 8'h05, 8'h00, 8'h80));
    send_report(keys_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(keys_of(8'h2a, 8'h2b, 8'h29, 8'h31, 8'h33, 8'h35));
    send_report(keys_of(8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h34, 8'h36));
    send_report(keys_of(8'h37, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    // short delay, repeat on every tick
    set_config(16'd2, 16'd1, 1'b1);
    send_report(keys_of(8'h04, 8'h05, 8'h00, 8'h39, 8'h00, 8'h00));
    repeat (4) send_tick();
    send_report(keys_of(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06));
    send_tick();

    // zero period: one repeat exactly at the delay
    set_config(16'd3, 16'd0, 1'b1);
    send_report(keys_of(8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (5) send_tick();

    set_config(16'd0, 16'd1, 1'b1);
    send_report(keys_of(8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (2) send_tick();

    set_config(16'd3, 16'd2, 1'b1);
    typing_session(ITEMS_PER_PHASE, 55);

    quiet <= 1'b1;
    set_config(16'd0, 16'd1, 1'b1);
    typing_session(ITEMS_PER_PHASE, 55);
    quiet <= 1'b0;

    set_config(16'hffff, 16'hffff, 1'b1);
    typing_session(ITEMS_PER_PHASE, 50);

    set_config(16'd5, 16'd0, 1'b1);
    typing_session(ITEMS_PER_PHASE, 55);

    set_config(16'd1, 16'd3, 1'b0);
    typing_session(60, 40);

    set_config(CNT_W'($urandom_range(12)), CNT_W'($urandom_range(6, 1)), 1'b1);
    typing_session(ITEMS_PER_PHASE, 55);

    drain();
    if (ledger.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/hbkt_pkg.sv
hdl/hbkt_front.sv
hdl/hbkt_queue.sv
hdl/hbkt_back.sv
hdl/hid_boot_keyboard_typematic_top.sv
verif/hid_boot_keyboard_typematic_top_test.sv
